### hdl/strongly_connected_component_count_macros.svh
// Assertion macros for the strongly connected component counter.
// Used by the port checker; depends on nothing else.
`ifndef STRONGLY_CONNECTED_COMPONENT_COUNT_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENT_COUNT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is asserted.
`define SCC_ASSERT_CR(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define SCC_ASSERT(label, prop, msg) \
    `SCC_ASSERT_CR(label, i_clk, i_rst_n, prop, msg)

`endif

### hdl/scc_pkg.sv
// Shared types and constants for the strongly connected component counter.
// Used by scc_ctrl, scc_dp and the top level; depends on nothing.
`default_nettype none
package scc_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_P1_ROOT, S_P1_SCAN, S_P1_EDGE, S_P1_POP,
        S_P2_ROOT, S_P2_ROOTRD, S_P2_SCAN, S_P2_EDGE, S_P2_POP, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE, DP_ADD, DP_CLEAR, DP_NOP, DP_START,
        DP_P1_ROOT, DP_P1_SCAN, DP_P1_EDGE, DP_P1_POP,
        DP_P2_ROOT, DP_P2_ROOTRD, DP_P2_SCAN, DP_P2_EDGE, DP_P2_POP, DP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic out_free;
        logic root_end;
        logic root_vis;
        logic scan_end;
        logic stack_empty;
        logic k_zero;
        logic root2_vis;
    } t_dp_stat;
endpackage
`default_nettype wire

### hdl/strongly_connected_component_count.sv
// Top level of the strongly connected component counter (Kosaraju).
// Instantiates scc_ctrl and scc_dp; depends on scc_pkg.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------
//   input   | i_in_valid, o_in_stall | i_opcode, i_edge_from, i_edge_to
//   output  | o_out_valid, i_out_stall | o_status, o_component_count
//   config  | i_cfg_we               | i_cfg_wdata (vertex_count)
//
// Add, clear and unused opcodes are handled without leaving idle; the next
// word is taken unless a stalled result still waits in the output register.
// Compute scans all held edges for each vertex in each pass, through the
// single edge store read port that every edge scan goes through.
// Reset is synchronous, clears the edge count, marks and result valid, and sets vertex_count to MAX_VERTICES.
// A stalled result holds; new words stall during compute and while it cannot be replaced.
`default_nettype none
module strongly_connected_component_count (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [scc_pkg::VTX_W-1:0]  i_edge_from,
    input  wire logic [scc_pkg::VTX_W-1:0]  i_edge_to,
    input  wire logic                       i_cfg_we,
    input  wire logic [scc_pkg::VCNT_W-1:0] i_cfg_wdata,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [1:0]                      o_status,
    output logic [scc_pkg::VCNT_W-1:0]      o_component_count
);
    scc_pkg::t_dp_op   op;
    scc_pkg::t_dp_stat stat;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_op       (op)
    );

    scc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_out_stall       (i_out_stall),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_component_count (o_component_count)
    );
endmodule
`default_nettype wire

### hdl/scc_dp.sv
// Datapath: edge store, walk stacks, finish order, visited marks, result register.
// Acts on one command per cycle from scc_ctrl; depends on scc_pkg.
`default_nettype none
module scc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire scc_pkg::t_dp_op               i_op,
    input  wire logic [scc_pkg::VTX_W-1:0]     i_edge_from,
    input  wire logic [scc_pkg::VTX_W-1:0]     i_edge_to,
    input  wire logic                          i_cfg_we,
    input  wire logic [scc_pkg::VCNT_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_out_stall,
    output scc_pkg::t_dp_stat                  o_stat,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic [scc_pkg::VCNT_W-1:0]         o_component_count
);
    localparam int VW = scc_pkg::VTX_W;
    localparam int CW = scc_pkg::VCNT_W;
    localparam int EW = scc_pkg::EIDX_W;
    localparam int HW = scc_pkg::ECNT_W;

    logic [CW-1:0] r_vcount;
    logic [HW-1:0] r_held;
    logic [2*VW-1:0] r_edge_mem [scc_pkg::MAX_EDGES];
    logic [VW-1:0] r_vstk [scc_pkg::MAX_VERTICES];
    logic [HW-1:0] r_estk [scc_pkg::MAX_VERTICES];
    logic [VW-1:0] r_fin  [scc_pkg::MAX_VERTICES];
    logic [scc_pkg::MAX_VERTICES-1:0] r_visited;
    logic [2*VW-1:0] r_edge_rd;
    logic [VW-1:0] r_vstk_rd;
    logic [HW-1:0] r_estk_rd;
    logic [VW-1:0] r_fin_rd;
    logic [CW-1:0] r_root, r_fin_cnt, r_k, r_depth, r_count;
    logic [VW-1:0] r_cur_v;
    logic [HW-1:0] r_cur_e;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [CW-1:0] r_out_count;

    logic [CW-1:0] n;
    logic [CW-1:0] depth_m1, k_m1;
    logic [VW-1:0] e_src, e_dst;
    logic          out_free, out_load, p1_push, p2_push;
    logic [1:0]    add_status;

    assign n = (r_vcount > CW'(scc_pkg::MAX_VERTICES)) ? CW'(scc_pkg::MAX_VERTICES)
                                                       : r_vcount;
    assign depth_m1 = r_depth - CW'(1);
    assign k_m1     = r_k - CW'(1);
    assign e_src    = r_edge_rd[2*VW-1:VW];
    assign e_dst    = r_edge_rd[VW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (i_op == scc_pkg::DP_ADD) || (i_op == scc_pkg::DP_CLEAR) ||
                      (i_op == scc_pkg::DP_NOP) || (i_op == scc_pkg::DP_FINISH);

    assign p1_push = (e_src == r_cur_v) && ({1'b0, e_dst} < n) && !r_visited[e_dst];
    assign p2_push = (e_dst == r_cur_v) && ({1'b0, e_src} < n) && !r_visited[e_src];

    always_comb begin
        if (({1'b0, i_edge_from} >= n) || ({1'b0, i_edge_to} >= n)) begin
            add_status = scc_pkg::ST_RANGE;
        end else if (r_held == HW'(scc_pkg::MAX_EDGES)) begin
            add_status = scc_pkg::ST_FULL;
        end else begin
            add_status = scc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_stat.out_free    = out_free;
        o_stat.root_end    = r_root >= n;
        o_stat.root_vis    = r_visited[r_root[VW-1:0]];
        o_stat.scan_end    = r_cur_e >= r_held;
        o_stat.stack_empty = r_depth == '0;
        o_stat.k_zero      = r_k == '0;
        o_stat.root2_vis   = r_visited[r_fin_rd];
    end

    // Memory ports: reads follow the current cursors and are registered.
    always_ff @(posedge i_clk) begin
        r_edge_rd <= r_edge_mem[r_cur_e[EW-1:0]];
        r_vstk_rd <= r_vstk[depth_m1[VW-1:0]];
        r_estk_rd <= r_estk[depth_m1[VW-1:0]];
        r_fin_rd  <= r_fin[k_m1[VW-1:0]];
        if (i_op == scc_pkg::DP_ADD && add_status == scc_pkg::ST_OK) begin
            r_edge_mem[r_held[EW-1:0]] <= {i_edge_from, i_edge_to};
        end
        if (i_op == scc_pkg::DP_P1_EDGE && p1_push) begin
            r_vstk[r_depth[VW-1:0]] <= r_cur_v;
            r_estk[r_depth[VW-1:0]] <= r_cur_e + HW'(1);
        end
        if (i_op == scc_pkg::DP_P2_EDGE && p2_push) begin
            r_vstk[r_depth[VW-1:0]] <= e_src;
        end
        if (i_op == scc_pkg::DP_P1_SCAN && o_stat.scan_end) begin
            r_fin[r_fin_cnt[VW-1:0]] <= r_cur_v;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            scc_pkg::DP_START: begin
                r_root    <= '0;
                r_fin_cnt <= '0;
            end
            scc_pkg::DP_P1_ROOT: begin
                if (o_stat.root_end) begin
                    r_k     <= r_fin_cnt;
                    r_count <= '0;
                end else if (o_stat.root_vis) begin
                    r_root <= r_root + CW'(1);
                end else begin
                    r_cur_v <= r_root[VW-1:0];
                    r_cur_e <= '0;
                    r_depth <= '0;
                end
            end
            scc_pkg::DP_P1_SCAN: begin
                if (o_stat.scan_end) begin
                    r_fin_cnt <= r_fin_cnt + CW'(1);
                    if (o_stat.stack_empty) begin
                        r_root <= r_root + CW'(1);
                    end
                end
            end
            scc_pkg::DP_P1_EDGE: begin
                if (p1_push) begin
                    r_depth <= r_depth + CW'(1);
                    r_cur_v <= e_dst;
                    r_cur_e <= '0;
                end else begin
                    r_cur_e <= r_cur_e + HW'(1);
                end
            end
            scc_pkg::DP_P1_POP: begin
                r_cur_v <= r_vstk_rd;
                r_cur_e <= r_estk_rd;
                r_depth <= depth_m1;
            end
            scc_pkg::DP_P2_ROOTRD: begin
                r_k <= k_m1;
                if (!o_stat.root2_vis) begin
                    r_count <= r_count + CW'(1);
                    r_cur_v <= r_fin_rd;
                    r_cur_e <= '0;
                    r_depth <= '0;
                end
            end
            scc_pkg::DP_P2_EDGE: begin
                if (p2_push) begin
                    r_depth <= r_depth + CW'(1);
                end
                r_cur_e <= r_cur_e + HW'(1);
            end
            scc_pkg::DP_P2_POP: begin
                r_cur_v <= r_vstk_rd;
                r_cur_e <= '0;
                r_depth <= depth_m1;
            end
            default: begin
            end
        endcase
    end

    // Control registers: config, edge count, visited marks, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= CW'(scc_pkg::MAX_VERTICES);
            r_held      <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                scc_pkg::DP_ADD: begin
                    if (add_status == scc_pkg::ST_OK) begin
                        r_held <= r_held + HW'(1);
                    end
                end
                scc_pkg::DP_CLEAR: begin
                    r_held <= '0;
                end
                scc_pkg::DP_START: begin
                    r_visited <= '0;
                end
                scc_pkg::DP_P1_ROOT: begin
                    if (o_stat.root_end) begin
                        r_visited <= '0;
                    end else if (!o_stat.root_vis) begin
                        r_visited[r_root[VW-1:0]] <= 1'b1;
                    end
                end
                scc_pkg::DP_P1_EDGE: begin
                    if (p1_push) begin
                        r_visited[e_dst] <= 1'b1;
                    end
                end
                scc_pkg::DP_P2_ROOTRD: begin
                    r_visited[r_fin_rd] <= 1'b1;
                end
                scc_pkg::DP_P2_EDGE: begin
                    if (p2_push) begin
                        r_visited[e_src] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            scc_pkg::DP_ADD: begin
                r_status    <= add_status;
                r_out_count <= '0;
            end
            scc_pkg::DP_CLEAR, scc_pkg::DP_NOP: begin
                r_status    <= scc_pkg::ST_OK;
                r_out_count <= '0;
            end
            scc_pkg::DP_FINISH: begin
                r_status    <= scc_pkg::ST_OK;
                r_out_count <= r_count;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_component_count = r_out_count;
endmodule
`default_nettype wire

### hdl/scc_ctrl.sv
// Controller: sequences edge loads and the two depth-first passes.
// Issues one datapath command per cycle unless idle or waiting for the result register; depends on scc_pkg.
`default_nettype none
module scc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_opcode,
    input  wire scc_pkg::t_dp_stat i_stat,
    output logic                   o_in_stall,
    output scc_pkg::t_dp_op        o_op
);
    scc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = scc_pkg::DP_NONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    priority case (i_opcode)
                        scc_pkg::OP_ADD:   o_op = scc_pkg::DP_ADD;
                        scc_pkg::OP_CLEAR: o_op = scc_pkg::DP_CLEAR;
                        scc_pkg::OP_COMPUTE: begin
                            o_op    = scc_pkg::DP_START;
                            n_state = scc_pkg::S_P1_ROOT;
                        end
                        default: o_op = scc_pkg::DP_NOP;
                    endcase
                end
            end
            scc_pkg::S_P1_ROOT: begin
                o_op = scc_pkg::DP_P1_ROOT;
                if (i_stat.root_end) begin
                    n_state = scc_pkg::S_P2_ROOT;
                end else if (!i_stat.root_vis) begin
                    n_state = scc_pkg::S_P1_SCAN;
                end
            end
            scc_pkg::S_P1_SCAN: begin
                o_op = scc_pkg::DP_P1_SCAN;
                if (!i_stat.scan_end) begin
                    n_state = scc_pkg::S_P1_EDGE;
                end else if (i_stat.stack_empty) begin
                    n_state = scc_pkg::S_P1_ROOT;
                end else begin
                    n_state = scc_pkg::S_P1_POP;
                end
            end
            scc_pkg::S_P1_EDGE: begin
                o_op    = scc_pkg::DP_P1_EDGE;
                n_state = scc_pkg::S_P1_SCAN;
            end
            scc_pkg::S_P1_POP: begin
                o_op    = scc_pkg::DP_P1_POP;
                n_state = scc_pkg::S_P1_SCAN;
            end
            scc_pkg::S_P2_ROOT: begin
                o_op    = scc_pkg::DP_P2_ROOT;
                n_state = i_stat.k_zero ? scc_pkg::S_DONE : scc_pkg::S_P2_ROOTRD;
            end
            scc_pkg::S_P2_ROOTRD: begin
                o_op    = scc_pkg::DP_P2_ROOTRD;
                n_state = i_stat.root2_vis ? scc_pkg::S_P2_ROOT : scc_pkg::S_P2_SCAN;
            end
            scc_pkg::S_P2_SCAN: begin
                o_op = scc_pkg::DP_P2_SCAN;
                if (!i_stat.scan_end) begin
                    n_state = scc_pkg::S_P2_EDGE;
                end else if (i_stat.stack_empty) begin
                    n_state = scc_pkg::S_P2_ROOT;
                end else begin
                    n_state = scc_pkg::S_P2_POP;
                end
            end
            scc_pkg::S_P2_EDGE: begin
                o_op    = scc_pkg::DP_P2_EDGE;
                n_state = scc_pkg::S_P2_SCAN;
            end
            scc_pkg::S_P2_POP: begin
                o_op    = scc_pkg::DP_P2_POP;
                n_state = scc_pkg::S_P2_SCAN;
            end
            scc_pkg::S_DONE: begin
                // hold the count until the result register frees
                if (i_stat.out_free) begin
                    o_op    = scc_pkg::DP_FINISH;
                    n_state = scc_pkg::S_IDLE;
                end
            end
            default: n_state = scc_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/scc_checker.sv
// Port checker for the strongly connected component counter, bound to the top.
// Depends on scc_pkg and strongly_connected_component_count_macros.svh.
`default_nettype none
`include "strongly_connected_component_count_macros.svh"
module scc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [1:0]                 o_status,
    input wire logic [scc_pkg::VCNT_W-1:0] o_component_count
);
    `SCC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status), "stalled result changed")
    `SCC_ASSERT(a_no_overrun, i_in_valid && !o_in_stall && o_out_valid |-> !i_out_stall, "word taken over a waiting result")
    `SCC_ASSERT(a_err_zero, o_out_valid && o_status != scc_pkg::ST_OK |-> o_component_count == '0, "error result with nonzero count")
    `SCC_ASSERT(a_count_max, o_out_valid |-> o_component_count <= scc_pkg::VCNT_W'(scc_pkg::MAX_VERTICES), "count above vertex limit")
endmodule

bind strongly_connected_component_count scc_checker u_scc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_component_count (o_component_count)
);
`default_nettype wire
